// ===== hw/rtl/mmcspi_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcspi_pkg
// types and constants shared by the spi-mode card host sequencer
// ----------------------------------------------------------------------------
package mmcspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned BufAw      = $clog2(BlockBytes);
  localparam int unsigned CntW       = BufAw + 1;

  // item operation codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_CARD    = 2'd1,
    OP_BUF_WR  = 2'd2,
    OP_BUF_RD  = 2'd3
  } op_e;

  // request codes
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_ERASE = 3'd3;
  localparam logic [2:0] REQ_RAW   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CARD    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // register indexes
  localparam logic [1:0] REG_RESP_POLL = 2'd0;
  localparam logic [1:0] REG_DATA_POLL = 2'd1;
  localparam logic [1:0] REG_INIT_TRY  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT_CLK, PH_CMD_FRAME, PH_CMD_POLL, PH_CMD_TAIL, PH_INIT_GAP,
    PH_RD_TOKEN, PH_RD_DATA, PH_RD_TAIL, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP,
    PH_WR_BUSY1, PH_WR_GAP, PH_WR_BUSY2
  } phase_e;

  // result item
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] response_byte;
    logic [1:0] status;
    logic       done_res;
    logic       chip_select;
    logic [7:0] send_byte;
    logic       send_valid;
  } res_t;

endpackage

// ===== hw/rtl/mmc_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// mmc_spi_host_sequencer
// spi-mode card host job sequencer: init, block read/write, erase, raw command
// ----------------------------------------------------------------------------
// usage: each input item on the s_axis side is a start request, a card byte
// from the finished spi exchange, or a host buffer write/read. every item
// gives exactly one result item on m_axis: next byte to send with its chip
// select, the end of a job with status, buffer read data, or an empty item.
// the step is one pass of logic from the phase registers into the result
// register: a result appears in the cycle after its item is accepted, and one
// item can be taken every cycle while results are taken. the block buffer is
// a 512 x 8 memory with a registered read; its read of the item in flight is
// taken in the result stage. s_axis_tready stays high while the result
// register is empty or is being taken, so a stalled receiver holds the result
// and backs up the input. reset clears the phase to idle, the counters and
// the limits to their maximum; buffer contents are undefined until written.
// apb: response_poll_limit at 0x0, data_poll_limit at 0x4, init_retry_limit
// at 0x8, pready always high.
module mmc_spi_host_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation[1:0], request[4:2], block_number[36:5],
  // block_count[68:37], command_index[74:69], command_argument[106:75],
  // card_byte[114:107], buffer_index[123:115], buffer_data[131:124]
  input  logic [135:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: send_valid[0], send_byte[8:1], chip_select[9], done_res[10],
  // status[12:11], response_byte[20:13], read_data[28:21]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mmcspi_pkg::*;

  // input fields
  logic [1:0]  op;
  logic [2:0]  req;
  logic [31:0] blk, cnt, carg;
  logic [5:0]  cidx;
  logic [7:0]  b, bdata;
  logic [8:0]  bidx;
  assign op    = s_axis_tdata[1:0];
  assign req   = s_axis_tdata[4:2];
  assign blk   = s_axis_tdata[36:5];
  assign cnt   = s_axis_tdata[68:37];
  assign cidx  = s_axis_tdata[74:69];
  assign carg  = s_axis_tdata[106:75];
  assign b     = s_axis_tdata[114:107];
  assign bidx  = s_axis_tdata[123:115];
  assign bdata = s_axis_tdata[131:124];

  logic acc;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic [7:0]  rpl_q, irl_q;
  logic [15:0] dpl_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpl_q <= 8'hFF;
      dpl_q <= 16'hFFFF;
      irl_q <= 8'hFF;
    end else if (cfg_wr) begin
      if (paddr[3:2] == REG_RESP_POLL) rpl_q <= pwdata[7:0];
      if (paddr[3:2] == REG_DATA_POLL) dpl_q <= pwdata[15:0];
      if (paddr[3:2] == REG_INIT_TRY)  irl_q <= pwdata[7:0];
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_RESP_POLL: prdata = {24'd0, rpl_q};
      REG_DATA_POLL: prdata = {16'd0, dpl_q};
      REG_INIT_TRY:  prdata = {24'd0, irl_q};
      default:       prdata = 32'd0;
    endcase
  end

  // sequencer state
  phase_e      ph_q, ph_d;
  logic [2:0]  areq_q, areq_d;
  logic [CntW-1:0] bc_q, bc_d;
  logic [15:0] rc_q, rc_d;
  logic [7:0]  ac_q, ac_d;
  logic [5:0]  fc_q, fc_d;
  logic [31:0] fa_q, fa_d, ee_q, ee_d;
  logic        ps_q, ps_d;

  // buffer memory
  logic [7:0] mem [BlockBytes];
  logic       mwe, mre;
  logic [BufAw-1:0] mwa, mra;
  logic [7:0] mwd, mrd_q;

  // result stage control: buffer byte goes to send_byte or read_data
  logic       sel_send_d, sel_send_q, sel_rd_d, sel_rd_q;
  res_t       res_d, res_q;

  function automatic logic [7:0] fbyte(input logic [2:0] k, input logic [5:0] c,
                                        input logic [31:0] a);
    logic [7:0] r;
    unique case (k)
      3'd0:    r = {2'b01, c};
      3'd1:    r = a[31:24];
      3'd2:    r = a[23:16];
      3'd3:    r = a[15:8];
      3'd4:    r = a[7:0];
      default: r = 8'h95;
    endcase
    return r;
  endfunction

  always_comb begin
    res_t r;
    logic [7:0] resp;
    logic [7:0] acn;
    logic [CntW-1:0] bcn;
    logic [5:0] sc_idx;
    logic [31:0] sc_arg;
    logic sc;
    r = '0;
    ph_d = ph_q; areq_d = areq_q; bc_d = bc_q; rc_d = rc_q; ac_d = ac_q;
    fc_d = fc_q; fa_d = fa_q; ee_d = ee_q; ps_d = ps_q;
    mwe = 1'b0; mwa = bidx[BufAw-1:0]; mwd = bdata;
    mre = 1'b0; mra = bidx[BufAw-1:0];
    sel_send_d = 1'b0; sel_rd_d = 1'b0;
    sc = 1'b0; sc_idx = 6'd0; sc_arg = 32'd0;
    resp = fa_q[7:0];
    acn = ac_q + 8'd1;
    bcn = bc_q + 1'b1;
    unique case (op_e'(op))
      OP_START: begin
        if (ph_q != PH_IDLE || req > REQ_RAW) begin
          r.done_res = 1'b1; r.status = ST_REFUSED;
        end else begin
          areq_d = req; ac_d = 8'd0; ps_d = 1'b0;
          unique case (req)
            REQ_INIT: begin
              ph_d = PH_INIT_CLK; bc_d = '0;
              r.send_valid = 1'b1; r.send_byte = 8'hFF;
            end
            REQ_READ:  begin sc = 1'b1; sc_idx = 6'd17; sc_arg = {blk[22:0], 9'd0}; end
            REQ_WRITE: begin sc = 1'b1; sc_idx = 6'd24; sc_arg = {blk[22:0], 9'd0}; end
            REQ_ERASE: begin
              ee_d = {blk[22:0] + cnt[22:0] - 23'd1, 9'd0};
              sc = 1'b1; sc_idx = 6'd32; sc_arg = {blk[22:0], 9'd0};
            end
            default:   begin sc = 1'b1; sc_idx = cidx; sc_arg = carg; end
          endcase
        end
      end
      OP_CARD: begin
        unique case (ph_q)
          PH_INIT_CLK: begin
            bc_d = bcn;
            if (bcn < 10) begin r.send_valid = 1'b1; r.send_byte = 8'hFF; end
            else begin sc = 1'b1; sc_idx = 6'd0; end
          end
          PH_INIT_GAP: begin
            bc_d = bcn;
            if (bcn < 2) begin r.send_valid = 1'b1; r.send_byte = 8'hFF; end
            else begin ac_d = 8'd0; ps_d = 1'b0; sc = 1'b1; sc_idx = 6'd1; end
          end
          PH_CMD_FRAME: begin
            bc_d = bcn;
            r.send_valid = 1'b1; r.chip_select = 1'b1;
            if (bcn < 6) r.send_byte = fbyte(bcn[2:0], fc_q, fa_q);
            else begin ph_d = PH_CMD_POLL; r.send_byte = 8'hFF; end
          end
          PH_CMD_POLL: begin
            if (b != 8'hFF || rc_q >= {8'd0, rpl_q}) begin
              fa_d = {24'd0, b}; ph_d = PH_CMD_TAIL;
            end else rc_d = rc_q + 16'd1;
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
          end
          PH_CMD_TAIL: begin
            priority if (areq_q == REQ_INIT) begin
              if (fc_q == 6'd0) begin
                ac_d = acn; bc_d = '0;
                if (resp == 8'h01) begin
                  ph_d = PH_INIT_GAP; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end else if (acn >= irl_q) begin
                  ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_TIMEOUT;
                end else begin
                  ph_d = PH_INIT_CLK; r.send_valid = 1'b1; r.send_byte = 8'hFF;
                end
              end else if (fc_q == 6'd1) begin
                if (!ps_q) begin ps_d = 1'b1; sc = 1'b1; sc_idx = 6'd1; end
                else begin
                  ps_d = 1'b0; ac_d = acn;
                  if (resp == 8'h00) begin sc = 1'b1; sc_idx = 6'd59; end
                  else if (acn >= irl_q) begin
                    ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_TIMEOUT;
                  end else begin sc = 1'b1; sc_idx = 6'd1; end
                end
              end else if (fc_q == 6'd59) begin
                sc = 1'b1; sc_idx = 6'd16; sc_arg = 32'(BlockBytes);
              end else begin
                ph_d = PH_IDLE; r.done_res = 1'b1;
              end
            end else if (areq_q == REQ_RAW || areq_q > REQ_RAW) begin
              ph_d = PH_IDLE; r.done_res = 1'b1; r.response_byte = resp;
            end else if (resp != 8'h00) begin
              ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_CARD;
              r.response_byte = resp;
            end else if (areq_q == REQ_READ) begin
              ph_d = PH_RD_TOKEN; rc_d = 16'd0;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end else if (areq_q == REQ_WRITE) begin
              ph_d = PH_WR_DATA; bc_d = '0;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFE;
            end else begin
              if (fc_q == 6'd32) begin sc = 1'b1; sc_idx = 6'd33; sc_arg = ee_q; end
              else if (fc_q == 6'd33) begin sc = 1'b1; sc_idx = 6'd38; end
              else begin ph_d = PH_IDLE; r.done_res = 1'b1; end
            end
          end
          PH_RD_TOKEN: begin
            if (b == 8'hFE) begin
              ph_d = PH_RD_DATA; bc_d = '0;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end else if (rc_q >= dpl_q) begin
              ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_TIMEOUT;
            end else begin
              rc_d = rc_q + 16'd1;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end
          end
          PH_RD_DATA: begin
            mwe = 1'b1; mwa = bc_q[BufAw-1:0]; mwd = b;
            bc_d = bcn;
            if (bcn >= CntW'(BlockBytes)) begin ph_d = PH_RD_TAIL; bc_d = '0; end
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
          end
          PH_RD_TAIL: begin
            bc_d = bcn;
            if (bcn < 3) begin
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end else begin ph_d = PH_IDLE; r.done_res = 1'b1; end
          end
          PH_WR_DATA: begin
            r.send_valid = 1'b1; r.chip_select = 1'b1;
            if (bc_q < CntW'(BlockBytes)) begin
              mre = 1'b1; mra = bc_q[BufAw-1:0]; sel_send_d = 1'b1; bc_d = bcn;
            end else begin
              ph_d = PH_WR_CRC; bc_d = '0; r.send_byte = 8'hFF;
            end
          end
          PH_WR_CRC: begin
            if (bc_q == '0) bc_d = CntW'(1);
            else ph_d = PH_WR_RESP;
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
          end
          PH_WR_RESP: begin
            if (b[4:0] != 5'h05) begin
              ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_CARD;
              r.response_byte = b;
            end else begin
              ph_d = PH_WR_BUSY1; rc_d = 16'd0;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end
          end
          PH_WR_BUSY1, PH_WR_BUSY2: begin
            if (b != 8'h00) begin
              if (ph_q == PH_WR_BUSY2) begin ph_d = PH_IDLE; r.done_res = 1'b1; end
              else begin ph_d = PH_WR_GAP; r.send_valid = 1'b1; r.send_byte = 8'hFF; end
            end else if (rc_q >= dpl_q) begin
              ph_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_TIMEOUT;
            end else begin
              rc_d = rc_q + 16'd1;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
            end
          end
          PH_WR_GAP: begin
            ph_d = PH_WR_BUSY2;
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = 8'hFF;
          end
          default: ph_d = PH_IDLE;
        endcase
      end
      OP_BUF_WR: mwe = 1'b1;
      default:   begin mre = 1'b1; sel_rd_d = 1'b1; end
    endcase
    // command framing start
    if (sc) begin
      fc_d = sc_idx; fa_d = sc_arg; bc_d = '0; rc_d = 16'd0; ph_d = PH_CMD_FRAME;
      r.send_valid = 1'b1; r.chip_select = 1'b1; r.send_byte = {2'b01, sc_idx};
    end
    res_d = r;
  end

  // buffer memory ports
  always_ff @(posedge clk_i) begin
    if (acc && mwe) mem[mwa] <= mwd;
    if (acc && mre) mrd_q <= mem[mra];
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; areq_q <= '0; bc_q <= '0; rc_q <= '0; ac_q <= '0;
      fc_q <= '0; fa_q <= '0; ee_q <= '0; ps_q <= 1'b0;
      m_axis_tvalid <= 1'b0; sel_send_q <= 1'b0; sel_rd_q <= 1'b0;
    end else begin
      if (acc) begin
        ph_q <= ph_d; areq_q <= areq_d; bc_q <= bc_d; rc_q <= rc_d; ac_q <= ac_d;
        fc_q <= fc_d; fa_q <= fa_d; ee_q <= ee_d; ps_q <= ps_d;
        sel_send_q <= sel_send_d; sel_rd_q <= sel_rd_d;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (acc) res_q <= res_d;
  end

  // result assembly with the registered buffer byte
  res_t ro;
  always_comb begin
    ro = res_q;
    if (sel_send_q) ro.send_byte = mrd_q;
    if (sel_rd_q)   ro.read_data = mrd_q;
  end
  assign m_axis_tdata = {3'd0, ro};

endmodule
